@@ design/mcqt_pkg.sv @@
// ----------------------------------------------------------------------------
// mcqt_pkg
// Shared types and constants for the monotonic clock quantum timebase:
// action codes, sequencer states, deadline status codes and the divider
// request/response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mcqt_pkg;

	// nanosecond fields and one second in nanoseconds
	localparam int unsigned      NS_W       = 30;
	localparam logic [NS_W-1:0]  NS_PER_SEC = 30'd1000000000;
	localparam logic [NS_W-1:0]  QLEN_RESET = 30'd1000000;
	localparam logic [30:0]      NS_2SEC    = 31'd2000000000;

	// magnitude of a conversion dividend and the divider step count
	localparam int unsigned MAG_W     = 61;
	localparam int unsigned DIV_STEPS = MAG_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// actions
	typedef enum logic [2:0] {
		ACT_TICK        = 3'd0,
		ACT_READ        = 3'd1,
		ACT_CHECK       = 3'd2,
		ACT_TO_QUANTA   = 3'd3,
		ACT_TO_INTERVAL = 3'd4
	} action_t;

	// deadline status codes
	localparam logic [1:0] DLY_NONE    = 2'd0;
	localparam logic [1:0] DLY_FAR     = 2'd1;
	localparam logic [1:0] DLY_WAIT    = 2'd2;
	localparam logic [1:0] DLY_REACHED = 2'd3;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIMPLE,
		ST_CHECK,
		ST_MUL,
		ST_ADD,
		ST_NEG,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [NS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [31:0]     quotient;
		logic [NS_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ design/mcqt_div.sv @@
// ----------------------------------------------------------------------------
// mcqt_div
// Restoring divider, one quotient bit per cycle. Divides an unsigned 61-bit
// magnitude by a 30-bit divisor; returns the low 32 quotient bits and the
// full remainder, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module mcqt_div import mcqt_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NS_W-1:0]      rem_q;
	logic [MAG_W-1:0]     dvd_q;
	logic [NS_W-1:0]      dsr_q;

	logic [NS_W:0]        trial;
	logic                 fits;
	logic [NS_W:0]        trial_sub;

	// trial subtraction of the divisor from the shifted partial remainder
	always_comb begin
		trial     = {rem_q, dvd_q[MAG_W-1]};
		fits      = (trial >= {1'b0, dsr_q});
		trial_sub = trial - {1'b0, dsr_q};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[NS_W-1:0] : trial[NS_W-1:0];
			dvd_q <= {dvd_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q[31:0];
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

@@ design/monotonic_clock_quantum_timebase.sv @@
// ----------------------------------------------------------------------------
// monotonic_clock_quantum_timebase
// Seconds/nanoseconds monotonic clock with a quantum tick counter. Performs
// tick, read, deadline check and the two interval/quanta conversions.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser action, tdata operands
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata result
//  cfg       in         cfg_wen                        cfg_wdata quantum length
//
//  Tick, read and unknown actions go from acceptance through ST_SIMPLE and ST_DONE
//  to the output register, a deadline check also through ST_CHECK. Both
//  conversions use one multiply, one add and one negate, then the shared 61-step
//  restoring divider. The next transaction can be accepted in the cycle after the
//  output register loads. One transaction is in work at a time; the output
//  register lets the next one be accepted while a result waits. Reset clears the
//  clock to zero and sets the quantum length to 1 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module monotonic_clock_quantum_timebase import mcqt_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	// configuration
	input  wire          cfg_wen,
	input  wire  [29:0]  cfg_wdata,
	// input stream
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: elapsed_ns[29:0], interval_secs[61:30], interval_nanos[91:62],
	//        round_away[92], quanta_in[124:93], zero fill[127:125]
	input  wire  [127:0] s_axis_tdata,
	// tuser: action[2:0]
	input  wire  [2:0]   s_axis_tuser,
	// output stream
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// tdata: time_secs[31:0], time_nanos[62:32], quanta_out[94:63],
	//        delay_status[96:95], tick_count[128:97], zero fill[135:129]
	output logic [135:0] m_axis_tdata
);

	state_t state_q, state_d;

	// configuration and clock state
	logic [NS_W-1:0] qlen_q;
	logic [NS_W-1:0] eff_len;
	logic [31:0]     secs_q;
	logic [NS_W-1:0] nanos_q;
	logic [31:0]     ticks_q;

	// captured transaction
	logic [2:0]      act_q;
	logic [NS_W-1:0] el_q;
	logic [31:0]     isecs_q;
	logic [NS_W-1:0] inanos_q;
	logic            away_q;
	logic [31:0]     qin_q;

	// result under construction
	logic [31:0]     res_secs_q;
	logic [30:0]     res_nanos_q;
	logic [31:0]     res_quanta_q;
	logic [1:0]      res_status_q;

	// conversion datapath
	logic signed [62:0] prod_q;
	logic signed [63:0] total_q;
	logic signed [31:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [62:0] mul_p;
	logic        [63:0] total_mag;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// output register
	logic         out_valid_q;
	logic [135:0] out_data_q;

	logic in_fire;
	logic out_load;

	// now-time, tick and deadline arithmetic
	logic [30:0]        nsum, nsub1, nsub2;
	logic [31:0]        now_secs;
	logic [NS_W-1:0]    now_nanos;
	logic [30:0]        tsum, tsub;
	logic [31:0]        tick_secs;
	logic [NS_W-1:0]    tick_nanos;
	logic signed [32:0] dsec;
	logic signed [33:0] dns;
	logic signed [33:0] dtot;
	logic [1:0]         dstatus;
	logic [31:0]        qmag_signed;
	logic [31:0]        conv_q;
	logic [30:0]        conv_rem;

	assign in_fire  = s_axis_tvalid && s_axis_tready;

	// clamp the quantum length to 1 ns .. 1 s
	always_comb begin
		if (qlen_q == '0) begin
			eff_len = NS_W'(1);
		end else if (qlen_q > NS_PER_SEC) begin
			eff_len = NS_PER_SEC;
		end else begin
			eff_len = qlen_q;
		end
	end

	// current time plus elapsed nanoseconds, up to two second carries
	always_comb begin
		nsum  = {1'b0, nanos_q} + {1'b0, el_q};
		nsub1 = nsum - {1'b0, NS_PER_SEC};
		nsub2 = nsum - NS_2SEC;
		if (nsum >= NS_2SEC) begin
			now_secs  = secs_q + 32'd2;
			now_nanos = nsub2[NS_W-1:0];
		end else if (nsum >= {1'b0, NS_PER_SEC}) begin
			now_secs  = secs_q + 32'd1;
			now_nanos = nsub1[NS_W-1:0];
		end else begin
			now_secs  = secs_q;
			now_nanos = nsum[NS_W-1:0];
		end
	end

	// advance the clock by one quantum
	always_comb begin
		tsum = {1'b0, nanos_q} + {1'b0, eff_len};
		tsub = tsum - {1'b0, NS_PER_SEC};
		if (tsum >= {1'b0, NS_PER_SEC}) begin
			tick_secs  = secs_q + 32'd1;
			tick_nanos = tsub[NS_W-1:0];
		end else begin
			tick_secs  = secs_q;
			tick_nanos = tsum[NS_W-1:0];
		end
	end

	// deadline minus now; only second differences of -1..1 need the exact sum
	always_comb begin
		dsec = $signed({isecs_q[31], isecs_q}) - $signed({res_secs_q[31], res_secs_q});
		dns  = $signed({4'b0, inanos_q}) - $signed({4'b0, res_nanos_q[NS_W-1:0]});
		if (dsec == 33'sd1) begin
			dtot = dns + 34'sd1000000000;
		end else if (dsec == -33'sd1) begin
			dtot = dns - 34'sd1000000000;
		end else begin
			dtot = dns;
		end
		if (dsec > 33'sd1) begin
			dstatus = DLY_FAR;
		end else if (dsec < -33'sd1) begin
			dstatus = DLY_REACHED;
		end else if (dtot > 34'sd1000000) begin
			dstatus = DLY_FAR;
		end else if (dtot > 34'sd0) begin
			dstatus = DLY_WAIT;
		end else begin
			dstatus = DLY_REACHED;
		end
	end

	// shared multiplier: seconds by one second, or quanta by quantum length
	always_comb begin
		if (act_q == ACT_TO_QUANTA) begin
			mul_a = $signed(isecs_q);
			mul_b = $signed({1'b0, NS_PER_SEC});
		end else begin
			mul_a = $signed(qin_q);
			mul_b = $signed({1'b0, eff_len});
		end
		mul_p = mul_a * mul_b;
	end

	// divider request: magnitude of the total over the selected divisor
	always_comb begin
		total_mag        = total_q[63] ? 64'(-total_q) : 64'(total_q);
		div_req.start    = (state_q == ST_DIV) ? 1'b0 : (state_q == ST_NEG);
		div_req.dividend = total_mag[MAG_W-1:0];
		div_req.divisor  = (act_q == ACT_TO_QUANTA) ? eff_len : NS_PER_SEC;
	end

	mcqt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// restore the sign of quotient and remainder; with round_away, round a positive inexact quotient up
	always_comb begin
		qmag_signed = total_q[63] ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
		if (away_q && !total_q[63] && (div_rsp.remainder != '0)) begin
			conv_q = qmag_signed + 32'd1;
		end else begin
			conv_q = qmag_signed;
		end
		conv_rem = total_q[63] ? (31'd0 - {1'b0, div_rsp.remainder})
		                       : {1'b0, div_rsp.remainder};
	end

	// sequencer next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if ((s_axis_tuser == ACT_TO_QUANTA) || (s_axis_tuser == ACT_TO_INTERVAL)) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_SIMPLE;
					end
				end
			end
			ST_SIMPLE: begin
				state_d = (act_q == ACT_CHECK) ? ST_CHECK : ST_DONE;
			end
			ST_CHECK: begin
				state_d = ST_DONE;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_NEG;
			end
			ST_NEG: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register, configuration, clock state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qlen_q      <= QLEN_RESET;
			secs_q      <= '0;
			nanos_q     <= '0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				qlen_q <= cfg_wdata;
			end
			if ((state_q == ST_SIMPLE) && (act_q == ACT_TICK)) begin
				secs_q  <= tick_secs;
				nanos_q <= tick_nanos;
				ticks_q <= ticks_q + 32'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the transaction and build the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q    <= s_axis_tuser;
			el_q     <= s_axis_tdata[29:0];
			isecs_q  <= s_axis_tdata[61:30];
			inanos_q <= s_axis_tdata[91:62];
			away_q   <= s_axis_tdata[92];
			qin_q    <= s_axis_tdata[124:93];
		end
		case (state_q)
			ST_SIMPLE: begin
				res_quanta_q <= '0;
				res_status_q <= DLY_NONE;
				if (act_q == ACT_TICK) begin
					res_secs_q  <= tick_secs;
					res_nanos_q <= {1'b0, tick_nanos};
				end else if ((act_q == ACT_READ) || (act_q == ACT_CHECK)) begin
					res_secs_q  <= now_secs;
					res_nanos_q <= {1'b0, now_nanos};
				end else begin
					res_secs_q  <= '0;
					res_nanos_q <= '0;
				end
			end
			ST_CHECK: begin
				res_status_q <= dstatus;
			end
			ST_MUL: begin
				prod_q <= mul_p;
			end
			ST_ADD: begin
				total_q <= 64'(prod_q)
				         + ((act_q == ACT_TO_QUANTA) ? $signed({34'b0, inanos_q}) : 64'sd0);
			end
			ST_FIX: begin
				res_status_q <= DLY_NONE;
				if (act_q == ACT_TO_QUANTA) begin
					res_secs_q   <= '0;
					res_nanos_q  <= '0;
					res_quanta_q <= conv_q;
				end else begin
					res_secs_q   <= qmag_signed;
					res_nanos_q  <= conv_rem;
					res_quanta_q <= '0;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= {7'b0, ticks_q, res_status_q, res_quanta_q, res_nanos_q, res_secs_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
